FILE: hdl/mms_pkg.sv
// ----------------------------------------------------------------------------
// mms_pkg
// shared types and constants of the memory map sanitizer
// ----------------------------------------------------------------------------
package mms_pkg;

    localparam int ADDR_W = 64;
    localparam int KIND_W = 3;
    localparam int CODE_W = 8;

    // region kinds, ordered by priority
    localparam logic [KIND_W-1:0] KIND_UNKNOWN     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FREE        = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RECLAIMABLE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RESERVED    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONVOLATILE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BAD         = 3'd5;

    // raw type codes
    localparam logic [CODE_W-1:0] CODE_FREE        = 8'd1;
    localparam logic [CODE_W-1:0] CODE_RESERVED    = 8'd2;
    localparam logic [CODE_W-1:0] CODE_RECLAIMABLE = 8'd3;
    localparam logic [CODE_W-1:0] CODE_NONVOLATILE = 8'd4;
    localparam logic [CODE_W-1:0] CODE_BAD         = 8'd5;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
        logic [KIND_W-1:0] kind;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_NEXT,
        S_SORT_KEY,
        S_SORT_CHK,
        S_SORT_CMP,
        S_RES_INIT,
        S_RES_FIRST,
        S_RES_RD,
        S_RES_CALC,
        S_RES_APPLY,
        S_MRG_INIT,
        S_MRG_FIRST,
        S_MRG_RD,
        S_MRG_STEP,
        S_FLUSH
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SORT_RD_I,
        OP_SORT_KEY,
        OP_SORT_RD_J,
        OP_SORT_WR_KEY,
        OP_SORT_SHIFT,
        OP_RES_START,
        OP_CUR_LOAD,
        OP_RD_NEXT,
        OP_RES_END,
        OP_RES_CALC,
        OP_RES_APPLY,
        OP_MRG_START,
        OP_MRG_END,
        OP_MRG_STEP,
        OP_FLUSH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic i_done;
        logic j_zero;
        logic base_gt;
        logic rp_end;
        logic cnt_zero;
    } t_status;

    function automatic logic [KIND_W-1:0] kind_from_code(input logic [CODE_W-1:0] code);
        logic [KIND_W-1:0] k;
        case (code)
            CODE_FREE:        k = KIND_FREE;
            CODE_RESERVED:    k = KIND_RESERVED;
            CODE_RECLAIMABLE: k = KIND_RECLAIMABLE;
            CODE_NONVOLATILE: k = KIND_NONVOLATILE;
            CODE_BAD:         k = KIND_BAD;
            default:          k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

FILE: hdl/mms_ctrl.sv
// ----------------------------------------------------------------------------
// mms_ctrl
// sequencer for load, sort, overlap resolve, merge and flush
// ----------------------------------------------------------------------------
module mms_ctrl
    import mms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    i_final_entry,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && i_final_entry) n_state = S_SORT_NEXT;
            end
            S_SORT_NEXT: n_state = i_status.i_done ? S_RES_INIT : S_SORT_KEY;
            S_SORT_KEY:  n_state = S_SORT_CHK;
            S_SORT_CHK:  n_state = i_status.j_zero ? S_SORT_NEXT : S_SORT_CMP;
            S_SORT_CMP:  n_state = i_status.base_gt ? S_SORT_CHK : S_SORT_NEXT;
            S_RES_INIT:  n_state = i_status.cnt_zero ? S_IDLE : S_RES_FIRST;
            S_RES_FIRST: n_state = S_RES_RD;
            S_RES_RD:    n_state = i_status.rp_end ? S_MRG_INIT : S_RES_CALC;
            S_RES_CALC:  n_state = S_RES_APPLY;
            S_RES_APPLY: n_state = S_RES_RD;
            S_MRG_INIT:  n_state = S_MRG_FIRST;
            S_MRG_FIRST: n_state = S_MRG_RD;
            S_MRG_RD:    n_state = i_status.rp_end ? S_FLUSH : S_MRG_STEP;
            S_MRG_STEP:  n_state = S_MRG_RD;
            S_FLUSH:     n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = OP_NONE;
        busy     = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) o_cmd.op = OP_LOAD;
            end
            S_SORT_NEXT: o_cmd.op = i_status.i_done ? OP_NONE : OP_SORT_RD_I;
            S_SORT_KEY:  o_cmd.op = OP_SORT_KEY;
            S_SORT_CHK:  o_cmd.op = i_status.j_zero ? OP_SORT_WR_KEY : OP_SORT_RD_J;
            S_SORT_CMP:  o_cmd.op = i_status.base_gt ? OP_SORT_SHIFT : OP_SORT_WR_KEY;
            S_RES_INIT:  o_cmd.op = i_status.cnt_zero ? OP_FLUSH : OP_RES_START;
            S_RES_FIRST: o_cmd.op = OP_CUR_LOAD;
            S_RES_RD:    o_cmd.op = i_status.rp_end ? OP_RES_END : OP_RD_NEXT;
            S_RES_CALC:  o_cmd.op = OP_RES_CALC;
            S_RES_APPLY: o_cmd.op = OP_RES_APPLY;
            S_MRG_INIT:  o_cmd.op = OP_MRG_START;
            S_MRG_FIRST: o_cmd.op = OP_CUR_LOAD;
            S_MRG_RD:    o_cmd.op = i_status.rp_end ? OP_MRG_END : OP_RD_NEXT;
            S_MRG_STEP:  o_cmd.op = OP_MRG_STEP;
            S_FLUSH:     o_cmd.op = OP_FLUSH;
            default:     o_cmd.op = OP_NONE;
        endcase
    end

endmodule

FILE: hdl/mms_dp.sv
// ----------------------------------------------------------------------------
// mms_dp
// entry memory, sort/resolve/merge registers and result register
// ----------------------------------------------------------------------------
module mms_dp
    import mms_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [ADDR_W-1:0] i_region_base,
    input  logic [ADDR_W-1:0] i_region_size,
    input  logic [CODE_W-1:0] i_type_code,
    output logic              o_valid,
    output logic [ADDR_W-1:0] o_out_base,
    output logic [ADDR_W-1:0] o_out_size,
    output logic [KIND_W-1:0] o_region_kind,
    output logic              o_final_region,
    output logic              o_overflowed
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

    t_entry mem [MAX_ENTRIES];
    t_entry r_rd;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic [AW-1:0] rd_addr;

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_wp, n_wp;
    t_entry        r_key, n_key;
    t_entry        r_cur, n_cur;
    t_entry        r_nxt, n_nxt;
    logic [ADDR_W-1:0] r_ov, n_ov;
    logic          r_olap, n_olap;
    t_entry        r_pend, n_pend;
    logic          r_pend_v, n_pend_v;
    logic          r_valid, n_valid;
    t_entry        r_out, n_out;
    logic          r_out_final, n_out_final;

    logic [CW-1:0]     j_dec;
    logic [ADDR_W-1:0] clip_size;
    logic [ADDR_W-1:0] cur_end;
    logic              push_en;
    t_entry            push_e;

    assign j_dec     = r_j - CW'(1);
    assign clip_size = (i_region_size > ~i_region_base) ? ~i_region_base : i_region_size;
    assign cur_end   = r_cur.base + r_cur.size;

    assign o_status.i_done   = (r_i >= r_count);
    assign o_status.j_zero   = (r_j == '0);
    assign o_status.base_gt  = (r_rd.base > r_key.base);
    assign o_status.rp_end   = (r_rp == r_count);
    assign o_status.cnt_zero = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    always_comb begin
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_key       = r_key;
        n_cur       = r_cur;
        n_nxt       = r_nxt;
        n_ov        = r_ov;
        n_olap      = r_olap;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;
        n_valid     = 1'b0;
        n_out       = r_out;
        n_out_final = r_out_final;
        wr_en       = 1'b0;
        wr_addr     = r_wp[AW-1:0];
        wr_data     = r_cur;
        rd_addr     = r_rp[AW-1:0];
        push_en     = 1'b0;
        push_e      = r_cur;

        case (i_cmd.op)
            OP_LOAD: begin
                n_i = CW'(1);
                if (r_count < FULL) begin
                    wr_en   = 1'b1;
                    wr_addr = r_count[AW-1:0];
                    wr_data = '{base: i_region_base, size: clip_size,
                                kind: kind_from_code(i_type_code)};
                    n_count = r_count + CW'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end
            OP_SORT_RD_I: rd_addr = r_i[AW-1:0];
            OP_SORT_KEY: begin
                n_key = r_rd;
                n_j   = r_i;
            end
            OP_SORT_RD_J: rd_addr = j_dec[AW-1:0];
            OP_SORT_WR_KEY: begin
                wr_en   = 1'b1;
                wr_addr = r_j[AW-1:0];
                wr_data = r_key;
                n_i     = r_i + CW'(1);
            end
            OP_SORT_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_j[AW-1:0];
                wr_data = r_rd;
                n_j     = j_dec;
            end
            OP_RES_START, OP_MRG_START: begin
                rd_addr  = '0;
                n_rp     = CW'(1);
                n_wp     = '0;
                n_pend_v = 1'b0;
            end
            OP_CUR_LOAD: n_cur = r_rd;
            OP_RD_NEXT: begin
                rd_addr = r_rp[AW-1:0];
                n_rp    = r_rp + CW'(1);
            end
            OP_RES_END: begin
                wr_en   = 1'b1;
                n_count = r_wp + CW'(1);
            end
            OP_RES_CALC: begin
                n_nxt  = r_rd;
                n_olap = cur_end > r_rd.base;
                n_ov   = cur_end - r_rd.base;
            end
            OP_RES_APPLY: begin
                if (!r_olap || r_cur.kind == r_nxt.kind) begin
                    wr_en = 1'b1;
                    n_wp  = r_wp + CW'(1);
                    n_cur = r_nxt;
                end else if (r_cur.kind > r_nxt.kind) begin
                    // next region loses: trimmed from the front or dropped
                    if (r_ov <= r_nxt.size) begin
                        wr_en = 1'b1;
                        n_wp  = r_wp + CW'(1);
                        n_cur = '{base: r_nxt.base + r_ov, size: r_nxt.size - r_ov,
                                  kind: r_nxt.kind};
                    end
                end else begin
                    // current region loses: cut back or dropped
                    if (r_ov != r_cur.size) begin
                        wr_en   = 1'b1;
                        wr_data = '{base: r_cur.base, size: r_cur.size - r_ov,
                                    kind: r_cur.kind};
                        n_wp    = r_wp + CW'(1);
                    end
                    n_cur = r_nxt;
                end
            end
            OP_MRG_STEP: begin
                if (r_cur.kind == r_rd.kind && cur_end == r_rd.base) begin
                    n_cur.size = r_cur.size + r_rd.size;
                end else begin
                    push_en = 1'b1;
                    n_cur   = r_rd;
                end
            end
            OP_MRG_END: push_en = 1'b1;
            OP_FLUSH: begin
                if (r_pend_v) begin
                    n_valid     = 1'b1;
                    n_out       = r_pend;
                    n_out_final = 1'b1;
                end
                n_pend_v = 1'b0;
                n_count  = '0;
            end
            default: begin
            end
        endcase

        // hold one word back so the last one can carry the final mark
        if (push_en && push_e.size != '0) begin
            if (r_pend_v) begin
                n_valid     = 1'b1;
                n_out       = r_pend;
                n_out_final = 1'b0;
            end
            n_pend   = push_e;
            n_pend_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_pend_v <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_ovf    <= (i_cmd.op == OP_FLUSH) ? 1'b0 : n_ovf;
            r_pend_v <= n_pend_v;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_j         <= n_j;
        r_rp        <= n_rp;
        r_wp        <= n_wp;
        r_key       <= n_key;
        r_cur       <= n_cur;
        r_nxt       <= n_nxt;
        r_ov        <= n_ov;
        r_olap      <= n_olap;
        r_pend      <= n_pend;
        r_out       <= n_out;
        r_out_final <= n_out_final;
    end

    logic r_out_ovf;
    always_ff @(posedge i_clk) begin
        r_out_ovf <= r_ovf;
    end

    assign o_valid        = r_valid;
    assign o_out_base     = r_out.base;
    assign o_out_size     = r_out.size;
    assign o_region_kind  = r_out.kind;
    assign o_final_region = r_out_final;
    assign o_overflowed   = r_out_ovf;

endmodule

FILE: hdl/memory_map_sanitizer_unit.sv
// ----------------------------------------------------------------------------
// memory_map_sanitizer_unit
// cleans a loaded memory map: sort, overlap resolve, merge, emit
// ----------------------------------------------------------------------------
// Entries load one per cycle while busy is low. The entry marked final starts
// processing on an entry memory with one write port and one registered read
// port: insertion sort by base, an overlap pass, then a merge pass that
// emits the cleaned regions, then a flush. Each region word is shown for one
// cycle with o_valid and must be taken then; the receiver cannot stall. Busy
// stays high from the final entry until the last word is on the outputs; the
// next map may start loading in the cycle that shows it.
module memory_map_sanitizer_unit
    import mms_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ADDR_W-1:0] i_region_base,
    input  logic [ADDR_W-1:0] i_region_size,
    input  logic [CODE_W-1:0] i_type_code,
    input  logic              i_final_entry,
    output logic              o_valid,
    output logic [ADDR_W-1:0] o_out_base,
    output logic [ADDR_W-1:0] o_out_size,
    output logic [KIND_W-1:0] o_region_kind,
    output logic              o_final_region,
    output logic              o_overflowed
);

    t_cmd    cmd;
    t_status status;

    mms_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_final_entry (i_final_entry),
        .i_status      (status),
        .o_cmd         (cmd),
        .busy          (busy)
    );

    mms_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_region_base  (i_region_base),
        .i_region_size  (i_region_size),
        .i_type_code    (i_type_code),
        .o_valid        (o_valid),
        .o_out_base     (o_out_base),
        .o_out_size     (o_out_size),
        .o_region_kind  (o_region_kind),
        .o_final_region (o_final_region),
        .o_overflowed   (o_overflowed)
    );

endmodule
